[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL in this folder.
// No dependencies; expects a clock named i_clk and a reset named i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock, switched off while reset is low
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Implication check on the rising clock, switched off while reset is low
`define ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

[rtl/core/slcd_pkg.sv]
// Types and constants for the serial display command parser.
// No dependencies.
`timescale 1ns / 1ps

package slcd_pkg;

    // Result actions
    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_INIT  = 2'd1,
        ACT_FLUSH = 2'd2,
        ACT_LIGHT = 2'd3
    } t_action;

    // Configuration register indexes (APB word address)
    typedef enum logic [2:0] {
        REG_OWN_SEL  = 3'd0,
        REG_SEL_LOW  = 3'd1,
        REG_SEL_HIGH = 3'd2,
        REG_INIT     = 3'd3,
        REG_HOME     = 3'd4,
        REG_FLUSH    = 3'd5
    } t_reg_idx;

    // Fixed byte classes
    localparam logic [7:0] PRINT_LOW  = 8'h20;
    localparam logic [7:0] DEL_CODE   = 8'h7F;
    localparam logic [7:0] LIGHT_LOW  = 8'h88;
    localparam logic [7:0] LIGHT_HIGH = 8'h8F;
    localparam logic [7:0] SKIP_LOW   = 8'h90;
    localparam logic [7:0] SKIP_HIGH  = 8'h9F;
    localparam logic [7:0] CGRAM_LOW  = 8'h80;
    localparam logic [7:0] CGRAM_HIGH = 8'h87;
    localparam logic [6:0] DUTY_STEP  = 7'd20;
    localparam logic [6:0] DUTY_MAX   = 7'd100;

    // Reset values of the configuration registers
    localparam logic [7:0] RST_OWN_SEL  = 8'd17;
    localparam logic [7:0] RST_SEL_LOW  = 8'd16;
    localparam logic [7:0] RST_SEL_HIGH = 8'd19;
    localparam logic [7:0] RST_INIT     = 8'd1;
    localparam logic [7:0] RST_HOME     = 8'd2;
    localparam logic [7:0] RST_FLUSH    = 8'd3;

    // Backlight duty from the low three bits of a 0x88..0x8F byte, capped at 100
    function automatic logic [6:0] duty_of(input logic [2:0] step);
        logic [7:0] raw;
        raw = 8'(step) * 8'(DUTY_STEP);
        duty_of = (raw > 8'(DUTY_MAX)) ? DUTY_MAX : raw[6:0];
    endfunction

endpackage

[rtl/core/serial_lcd_command_parser.sv]
// Serial display command parser: byte decode, write position and APB registers.
// Depends on slcd_pkg and assert_macros.svh.
//
//   channel | direction | handshake                  | payload
//   rx      | in        | i_rx_valid / o_rx_stall    | i_rx_byte
//   out     | out       | o_out_valid / i_out_stall  | o_action, o_position,
//           |           |                            | o_char_code, o_duty_percent
//   apb     | in        | psel, penable, pready      | paddr, pwdata, pwrite, prdata
//
// One byte per cycle while o_rx_stall is low. A byte is decoded in the input register
// against the position and flags; its result (if any) moves into the output register.
// The output register is the only place a result waits; while it is stalled and full,
// a byte that makes a result holds in the input register and o_rx_stall rises.
// Bytes that make no result always pass. Synchronous active-low reset clears control.
`timescale 1ns / 1ps

module serial_lcd_command_parser #(
    parameter int BUFFER_CHARS = 160
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // received bytes
    input  logic                 i_rx_valid,
    output logic                 o_rx_stall,
    input  logic [7:0]           i_rx_byte,
    // results
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output slcd_pkg::t_action    o_action,
    output logic [7:0]           o_position,
    output logic [7:0]           o_char_code,
    output logic [6:0]           o_duty_percent,
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import slcd_pkg::*;

    `include "assert_macros.svh"

    localparam logic [7:0] BufLimit = 8'(BUFFER_CHARS);

    // configuration registers
    logic [7:0] r_own_sel, r_sel_low, r_sel_high, r_init_code, r_home_code, r_flush_code;
    t_reg_idx   reg_idx;

    // input stage
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // parser state
    logic [7:0] r_wpos, n_wpos;
    logic       r_active, n_active;
    logic       r_init_seen, n_init_seen;

    // output stage
    logic       r_out_valid;
    t_action    r_action, n_action;
    logic [7:0] r_position, n_position;
    logic [7:0] r_char_code, n_char_code;
    logic [6:0] r_duty, n_duty;
    logic       n_has_result;

    logic       out_free;
    logic       advance;
    logic       rx_accept;

    // APB: always ready, word addressed
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_sel    <= RST_OWN_SEL;
            r_sel_low    <= RST_SEL_LOW;
            r_sel_high   <= RST_SEL_HIGH;
            r_init_code  <= RST_INIT;
            r_home_code  <= RST_HOME;
            r_flush_code <= RST_FLUSH;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_OWN_SEL:  r_own_sel    <= pwdata[7:0];
                REG_SEL_LOW:  r_sel_low    <= pwdata[7:0];
                REG_SEL_HIGH: r_sel_high   <= pwdata[7:0];
                REG_INIT:     r_init_code  <= pwdata[7:0];
                REG_HOME:     r_home_code  <= pwdata[7:0];
                REG_FLUSH:    r_flush_code <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (reg_idx)
            REG_OWN_SEL:  prdata = {24'd0, r_own_sel};
            REG_SEL_LOW:  prdata = {24'd0, r_sel_low};
            REG_SEL_HIGH: prdata = {24'd0, r_sel_high};
            REG_INIT:     prdata = {24'd0, r_init_code};
            REG_HOME:     prdata = {24'd0, r_home_code};
            REG_FLUSH:    prdata = {24'd0, r_flush_code};
            default:      prdata = 32'd0;
        endcase
    end

    // decode of the byte in the input register
    always_comb begin
        n_wpos       = r_wpos;
        n_active     = r_active;
        n_init_seen  = r_init_seen;
        n_has_result = 1'b0;
        n_action     = ACT_WRITE;
        n_position   = 8'd0;
        n_char_code  = 8'd0;
        n_duty       = 7'd0;

        if (r_in_byte >= r_sel_low && r_in_byte <= r_sel_high) begin
            // device select
            n_active    = (r_in_byte == r_own_sel);
            n_init_seen = 1'b0;
        end else if (r_active) begin
            if (r_in_byte == r_init_code) begin
                n_init_seen = !r_init_seen;
                if (r_init_seen) begin
                    n_wpos       = 8'd0;
                    n_has_result = 1'b1;
                    n_action     = ACT_INIT;
                end
            end else begin
                n_init_seen = 1'b0;
                if (r_in_byte == r_home_code) begin
                    n_wpos = 8'd0;
                end else if (r_in_byte == r_flush_code) begin
                    n_wpos       = 8'd0;
                    n_has_result = 1'b1;
                    n_action     = ACT_FLUSH;
                end else if (r_in_byte < PRINT_LOW || r_in_byte == DEL_CODE) begin
                    // control byte without meaning: dropped
                end else if (r_in_byte inside {[LIGHT_LOW:LIGHT_HIGH]}) begin
                    n_has_result = 1'b1;
                    n_action     = ACT_LIGHT;
                    n_duty       = duty_of(r_in_byte[2:0]);
                end else if (r_in_byte inside {[SKIP_LOW:SKIP_HIGH]}) begin
                    // reserved range: dropped
                end else if (r_wpos < BufLimit) begin
                    // character write; CGRAM codes map to 0..7
                    n_has_result = 1'b1;
                    n_action     = ACT_WRITE;
                    n_position   = r_wpos;
                    n_char_code  = (r_in_byte inside {[CGRAM_LOW:CGRAM_HIGH]})
                                 ? {5'd0, r_in_byte[2:0]} : r_in_byte;
                    n_wpos       = r_wpos + 8'd1;
                end
            end
        end
    end

    // flow control between the stages
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && (!n_has_result || out_free);
    assign o_rx_stall = r_in_valid && !advance;
    assign rx_accept  = i_rx_valid && !o_rx_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (rx_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (rx_accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // parser state, updated once per decoded byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos      <= 8'd0;
            r_active    <= 1'b1;
            r_init_seen <= 1'b0;
        end else if (advance) begin
            r_wpos      <= n_wpos;
            r_active    <= n_active;
            r_init_seen <= n_init_seen;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && n_has_result;
        end
        if (out_free && advance && n_has_result) begin
            r_action    <= n_action;
            r_position  <= n_position;
            r_char_code <= n_char_code;
            r_duty      <= n_duty;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_action       = r_action;
    assign o_position     = r_position;
    assign o_char_code    = r_char_code;
    assign o_duty_percent = r_duty;

    // checks
    `ASSERT_CLK(a_wpos_bound, r_wpos <= BufLimit, "write position beyond buffer")
    `ASSERT_IMPL(a_write_in_buf, r_out_valid && r_action == ACT_WRITE,
        r_position < BufLimit, "character write outside buffer")
    `ASSERT_IMPL(a_duty_cap, r_out_valid && r_action == ACT_LIGHT,
        r_duty <= DUTY_MAX, "backlight duty above cap")
    `ASSERT_IMPL(a_held_byte_kept, r_in_valid && !advance,
        ##1 (r_in_valid && $stable(r_in_byte)), "stalled byte lost")

endmodule
